// ===== rtl/atan2_degrees_approx_defines.svh =====
// ============================================================================
// Assertion macros for the atan2_degrees_approx block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ============================================================================
`ifndef ATAN2_DEGREES_APPROX_DEFINES_SVH
`define ATAN2_DEGREES_APPROX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/a2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// a2d_pkg
// Types, widths and constants of the approximate atan2 pipeline.
// ============================================================================
package a2d_pkg;

  localparam int InW    = 16;  // input component width
  localparam int MagW   = 17;  // magnitude, holds 32768
  localparam int ProdW  = 31;  // product of two magnitudes, at most 2**30
  localparam int NumW   = 42;  // 3667 * 2**30 stays below 2**42
  localparam int DenW   = 37;  // 81 * 2**30 stays below 2**37
  localparam int QuotW  = 6;   // the first-octant quotient never exceeds 45
  localparam int AngW   = 10;

  localparam logic [11:0] NumCoef  = 12'd3667;
  localparam int          DenMajSh = 6;      // 64 * a^2
  localparam int          DenMinSh = 4;      // 17 * b^2 = 16 * b^2 + b^2

  localparam logic signed [AngW-1:0] AngZero     = 10'sd0;
  localparam logic signed [AngW-1:0] AngRight    = 10'sd90;
  localparam logic signed [AngW-1:0] AngNegRight = -10'sd90;
  localparam logic signed [AngW-1:0] AngHalf     = 10'sd180;
  localparam logic signed [AngW-1:0] AngMax      = 10'sd270;
  localparam logic [QuotW-1:0]       QuotMax     = 6'd45;

  // Stage map: prepare, multiply, form terms, one stage per quotient bit, output.
  localparam int StgPrep   = 0;
  localparam int StgMul    = 1;
  localparam int StgForm   = 2;
  localparam int StgDiv0   = 3;
  localparam int StgOut    = StgDiv0 + QuotW;
  localparam int NumStages = StgOut + 1;

  typedef struct packed {
    logic                   special;     // one component is zero
    logic signed [AngW-1:0] spec_angle;  // angle for that case
    logic                   swap;        // |y| > |x|
    logic                   neg_y;
    logic                   neg_x;
  } a2d_ctl_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic            qbit;
  } a2d_step_t;

  // One restoring division step against the denominator shifted by sh.
  function automatic a2d_step_t a2d_div_step(input logic [NumW-1:0] rem,
                                             input logic [DenW-1:0] den,
                                             input int unsigned     sh);
    logic [NumW-1:0] dsh;
    a2d_step_t       res;
    dsh = {{(NumW-DenW){1'b0}}, den} << sh;
    if (rem >= dsh) begin
      res.rem  = rem - dsh;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/atan2_degrees_approx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// atan2_degrees_approx
// Four-quadrant arctangent in whole degrees from atan(t) ~ t / (1 + 0.2656 t^2).
// ============================================================================
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | y_val_i, x_val_i (16b signed)
//  out      | source    | out_valid_o / out_stall_i| angle_deg_o (10b signed)
//
// The block takes one transaction per clock cycle while the output is not
// stalled. Its pipeline runs the prepare, multiply and term stages, then the
// six-stage restoring divider, one quotient bit per stage, then the output stage.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage advances when it is empty or when the stage after it advances, so
// a stall on the output fills bubbles first and then holds every stage intact.
//
// With a the larger and b the smaller magnitude, the first-octant angle is
// 3667*a*b / (64*a^2 + 17*b^2), truncated. Because b <= a that quotient is at
// most 45, so six quotient bits cover it. The octant, the sign of y and the
// sign of x then fold it out to the range -90..270. A zero component skips the
// arithmetic and takes a fixed angle carried alongside the data.
// ============================================================================
`include "atan2_degrees_approx_defines.svh"

module atan2_degrees_approx
  import a2d_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [InW-1:0]  y_val_i,
  input  wire logic signed [InW-1:0]  x_val_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [AngW-1:0]      angle_deg_o
);

  // Stage valid bits and per-stage advance enables.
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_d;
  logic [NumStages-1:0] en;

  // Control flags travel with every stage up to the output stage.
  a2d_ctl_t ctl_q [StgOut];
  a2d_ctl_t ctl_d;

  // Prepare stage: ordered magnitudes.
  logic [MagW-1:0] y_ext, x_ext, ay, ax;
  logic [MagW-1:0] a_q, b_q, a_d, b_d;

  // Multiply stage.
  logic [ProdW-1:0] aa_q, bb_q, ab_q;
  logic [2*MagW-1:0] aa_full, bb_full, ab_full;

  // Term stage.
  logic [NumW-1:0] z_q, z_d;
  logic [DenW-1:0] den_q, den_d;
  logic [NumW+11:0] z_full;

  // Divider stages.
  logic [NumW-1:0]  rem_q  [QuotW];
  logic [NumW-1:0]  rem_d  [QuotW];
  logic [DenW-1:0]  dden_q [QuotW];
  logic [QuotW-1:0] quot_q [QuotW];
  logic [QuotW-1:0] quot_d [QuotW];

  // Output stage.
  logic signed [AngW-1:0] angle_q, angle_d;

  // --------------------------------------------------------------------------
  // Flow control. The output stage drains when the consumer is not stalling;
  // every earlier stage may load when it is empty or its successor drains.
  // --------------------------------------------------------------------------
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        v_d[i] = v_q[i-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // --------------------------------------------------------------------------
  // Prepare stage: magnitudes, octant choice and the zero-component cases.
  // The most negative input has magnitude 32768, so magnitudes are 17 bits.
  // --------------------------------------------------------------------------
  always_comb begin
    y_ext = {y_val_i[InW-1], y_val_i};
    x_ext = {x_val_i[InW-1], x_val_i};
    ay    = y_val_i[InW-1] ? (~y_ext + 17'd1) : y_ext;
    ax    = x_val_i[InW-1] ? (~x_ext + 17'd1) : x_ext;

    ctl_d.swap  = ay > ax;
    ctl_d.neg_y = y_val_i[InW-1];
    ctl_d.neg_x = x_val_i[InW-1];
    a_d = ctl_d.swap ? ay : ax;
    b_d = ctl_d.swap ? ax : ay;

    ctl_d.special = (y_val_i == '0) || (x_val_i == '0);
    if (y_val_i == '0) begin
      ctl_d.spec_angle = x_val_i[InW-1] ? AngHalf : AngZero;
    end else begin
      ctl_d.spec_angle = y_val_i[InW-1] ? AngNegRight : AngRight;
    end
  end

  // --------------------------------------------------------------------------
  // Products and terms. Both magnitudes are at most 2**15, so every square
  // and cross product fits in 31 bits.
  // --------------------------------------------------------------------------
  assign aa_full = a_q * a_q;
  assign bb_full = b_q * b_q;
  assign ab_full = a_q * b_q;

  assign z_full = {{12{1'b0}}, {(NumW-ProdW){1'b0}}, ab_q} * {{(NumW){1'b0}}, NumCoef};
  assign z_d    = z_full[NumW-1:0];
  assign den_d  = ({{(DenW-ProdW){1'b0}}, aa_q} << DenMajSh)
                + ({{(DenW-ProdW){1'b0}}, bb_q} << DenMinSh)
                +  {{(DenW-ProdW){1'b0}}, bb_q};

  // --------------------------------------------------------------------------
  // Restoring divider: stage k decides quotient bit (QuotW-1-k).
  // --------------------------------------------------------------------------
  always_comb begin
    a2d_step_t st;
    for (int k = 0; k < QuotW; k++) begin
      if (k == 0) begin
        st        = a2d_div_step(z_q, den_q, QuotW - 1);
        quot_d[k] = {{(QuotW-1){1'b0}}, st.qbit};
      end else begin
        st        = a2d_div_step(rem_q[k-1], dden_q[k-1], QuotW - 1 - k);
        quot_d[k] = {quot_q[k-1][QuotW-2:0], st.qbit};
      end
      rem_d[k] = st.rem;
    end
  end

  // --------------------------------------------------------------------------
  // Fold the first-octant quotient out to the full circle.
  // --------------------------------------------------------------------------
  always_comb begin
    a2d_ctl_t               c;
    logic signed [AngW-1:0] q_ext, base, turned;
    c      = ctl_q[StgOut-1];
    q_ext  = signed'({{(AngW-QuotW){1'b0}}, quot_q[QuotW-1]});
    base   = c.swap  ? (AngRight - q_ext) : q_ext;
    turned = c.neg_y ? (AngZero - base) : base;
    if (c.special) begin
      angle_d = c.spec_angle;
    end else if (c.neg_x) begin
      angle_d = AngHalf - turned;
    end else begin
      angle_d = turned;
    end
  end

  // --------------------------------------------------------------------------
  // Data registers, loaded on their stage enable.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[StgPrep]) begin
      ctl_q[StgPrep] <= ctl_d;
      a_q            <= a_d;
      b_q            <= b_d;
    end
    for (int i = 1; i < StgOut; i++) begin
      if (en[i]) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
    if (en[StgMul]) begin
      aa_q <= aa_full[ProdW-1:0];
      bb_q <= bb_full[ProdW-1:0];
      ab_q <= ab_full[ProdW-1:0];
    end
    if (en[StgForm]) begin
      z_q   <= z_d;
      den_q <= den_d;
    end
    for (int k = 0; k < QuotW; k++) begin
      if (en[StgDiv0+k]) begin
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        dden_q[k] <= (k == 0) ? den_q : dden_q[k-1];
      end
    end
    if (en[StgOut]) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = v_q[StgOut];
  assign angle_deg_o = angle_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `A2D_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v_q[StgPrep],
    "accepted transaction did not enter the first stage")
  `A2D_ASSERT_IMP(a_den_nonzero, v_q[StgForm] && !ctl_q[StgForm].special,
    den_q != '0, "zero denominator on a non-special transaction")
  `A2D_ASSERT_IMP(a_quot_bound, v_q[StgOut-1] && !ctl_q[StgOut-1].special,
    quot_q[QuotW-1] <= QuotMax, "first-octant quotient above 45")
  `A2D_ASSERT_IMP(a_angle_range, out_valid_o,
    (angle_deg_o >= AngNegRight) && (angle_deg_o <= AngMax),
    "output angle outside -90..270")

endmodule
`default_nettype wire

// ===== verif/atan2_degrees_approx_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atan2_degrees_approx_test
// Self-checking bench for the approximate atan2 pipeline. A short directed
// table covers the axes, the diagonals and the most negative inputs. A long
// random run follows, with gaps on both channels and a predictor written at
// full 64-bit width. Results are compared in order against the queue of
// predicted angles.
// ============================================================================

module atan2_degrees_approx_test;
  import a2d_pkg::*;

  localparam int ClkHalf     = 6;          // 12 ns period
  localparam int ResetCycles = 11;
  localparam int RandomItems = 1400;
  localparam int HoldPoint   = 400;        // accepted count that starts the long stall
  localparam int LongHold    = 90;         // cycles the receiver holds off once
  localparam int DrainPoint  = 900;        // random item before which the sender waits
  localparam int TailCycles  = 30;         // settle time after the last result
  localparam int RunLimitNs  = 10_000_000;

  // Coefficients of the rational approximation: 3667*a*b / (64*a^2 + 17*b^2).
  localparam longint unsigned SlopeNum   = 3667;
  localparam longint unsigned MajorCoef  = 64;
  localparam longint unsigned MinorCoef  = 17;
  localparam int              QuarterDeg = 90;
  localparam int              HalfDeg    = 180;

  typedef struct {
    logic signed [InW-1:0]  y;
    logic signed [InW-1:0]  x;
    bit                     typed;   // angle below is written out by hand
    logic signed [AngW-1:0] angle;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic signed [InW-1:0]  y_val_i     = '0;
  logic signed [InW-1:0]  x_val_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [AngW-1:0] angle_deg_o;

  // Predicted angles, oldest first, one per accepted transaction.
  logic signed [AngW-1:0] angles_due[$];
  logic signed [AngW-1:0] due_angle;
  int                     mismatch_count = 0;
  int                     accepted_count = 0;
  stim_row_t              dir_rows[22];

  atan2_degrees_approx dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .y_val_i    (y_val_i),
    .x_val_i    (x_val_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .angle_deg_o(angle_deg_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Predictor. Magnitudes are 17 bits so that -32768 stays exact, and every
  // product is formed at 64 bits, so none of the terms can wrap.
  function automatic logic signed [AngW-1:0] approx_angle(input logic signed [InW-1:0] y,
                                                          input logic signed [InW-1:0] x);
    logic [InW:0]      mag_y;
    logic [InW:0]      mag_x;
    longint unsigned   num;
    longint unsigned   den;
    int                ang;
    if (y == 0) begin
      return (x >= 0) ? AngZero : AngHalf;
    end
    if (x == 0) begin
      return (y > 0) ? AngRight : AngNegRight;
    end
    mag_y = (y < 0) ? (InW+1)'(-int'(y)) : (InW+1)'(int'(y));
    mag_x = (x < 0) ? (InW+1)'(-int'(x)) : (InW+1)'(int'(x));
    num = SlopeNum * mag_x * mag_y;
    // Equal magnitudes stay in the lower octant, with x as the major term.
    if (mag_y <= mag_x) begin
      den = MajorCoef * mag_x * mag_x + MinorCoef * mag_y * mag_y;
      ang = int'(num / den);
    end else begin
      den = MajorCoef * mag_y * mag_y + MinorCoef * mag_x * mag_x;
      ang = QuarterDeg - int'(num / den);
    end
    // Fold out by quadrant: a negative y mirrors about the x axis, then a
    // negative x mirrors about the y axis.
    if (y < 0) begin
      ang = -ang;
    end
    if (x < 0) begin
      ang = HalfDeg - ang;
    end
    return AngW'(ang);
  endfunction

  function automatic stim_row_t row(input int y, input int x, input bit typed,
                                    input logic signed [AngW-1:0] angle);
    stim_row_t r;
    r.y     = InW'(y);
    r.x     = InW'(x);
    r.typed = typed;
    r.angle = angle;
    return r;
  endfunction

  // Sender gaps: mostly back to back, sometimes short, rarely long.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [InW-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0001;
      3: return 16'shffff;
      default: return 16'sh0000;
    endcase
  endfunction

  // Random operand pairs. Four in ten are uniform over the full range; the rest
  // aim at the axes, the diagonal where the octant flips, tiny magnitudes, the
  // extremes of the field, or one large and one small component.
  task automatic make_pair(output logic signed [InW-1:0] y,
                           output logic signed [InW-1:0] x);
    int m;
    int d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        y = InW'($urandom);
        x = InW'($urandom);
      end
      4: begin
        y = InW'(int'($urandom_range(0, 32)) - 16);
        x = InW'(int'($urandom_range(0, 32)) - 16);
      end
      5: begin
        m = int'($urandom_range(0, 65535)) - 32768;
        d = int'($urandom_range(0, 4)) - 2;
        x = InW'(m);
        y = InW'(($urandom_range(0, 1) ? m : -m) + d);
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          y = '0;
          x = InW'($urandom);
        end else begin
          y = InW'($urandom);
          x = '0;
        end
      end
      7: begin
        y = edge_value();
        x = edge_value();
      end
      default: begin
        // One large and one small component, in either order.
        m = int'($urandom_range(0, 65535)) - 32768;
        d = int'($urandom_range(0, 200)) - 100;
        if ($urandom_range(0, 1)) begin
          y = InW'(m);
          x = InW'(d);
        end else begin
          y = InW'(d);
          x = InW'(m);
        end
      end
    endcase
  endtask

  // Offers one transaction from a falling edge, holds it until the block
  // takes it, records the predicted angle and returns on the next falling edge.
  task automatic offer(input logic signed [InW-1:0] y, input logic signed [InW-1:0] x,
                       input bit typed, input logic signed [AngW-1:0] angle);
    in_valid_i <= 1'b1;
    y_val_i    <= y;
    x_val_i    <= x;
    do @(posedge clk_i); while (in_stall_o);
    angles_due.push_back(typed ? angle : approx_angle(y, x));
    accepted_count++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Stimulus: reset, the directed table, then the random run.
  initial begin : stimulus
    logic signed [InW-1:0] ry;
    logic signed [InW-1:0] rx;

    // Directed table. Axis cases carry their angle; the rest go to the predictor.
    dir_rows[0]  = row(0, 0, 1'b1, AngZero);
    dir_rows[1]  = row(0, 32767, 1'b1, AngZero);
    dir_rows[2]  = row(0, -1, 1'b1, AngHalf);
    dir_rows[3]  = row(0, -32768, 1'b1, AngHalf);
    dir_rows[4]  = row(1, 0, 1'b1, AngRight);
    dir_rows[5]  = row(-1, 0, 1'b1, AngNegRight);
    dir_rows[6]  = row(32767, 0, 1'b1, AngRight);
    dir_rows[7]  = row(-32768, 0, 1'b1, AngNegRight);
    dir_rows[8]  = row(1, 1, 1'b0, AngZero);
    dir_rows[9]  = row(-1, -1, 1'b0, AngZero);
    dir_rows[10] = row(32767, 32767, 1'b0, AngZero);
    dir_rows[11] = row(-32768, -32768, 1'b0, AngZero);
    dir_rows[12] = row(-32768, 32767, 1'b0, AngZero);
    dir_rows[13] = row(32767, -32768, 1'b0, AngZero);
    dir_rows[14] = row(1, 32767, 1'b0, AngZero);
    dir_rows[15] = row(32767, 1, 1'b0, AngZero);
    dir_rows[16] = row(-32768, 1, 1'b0, AngZero);
    dir_rows[17] = row(1, -32768, 1'b0, AngZero);
    dir_rows[18] = row(-1, -32768, 1'b0, AngZero);
    dir_rows[19] = row(-32768, -1, 1'b0, AngZero);
    dir_rows[20] = row(-200, 100, 1'b0, AngZero);
    dir_rows[21] = row(12345, -23456, 1'b0, AngZero);

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].y, dir_rows[i].x, dir_rows[i].typed, dir_rows[i].angle);
      idle_sender(sender_gap());
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Once in the run the sender stops until the pipeline has fully drained.
      if (n == DrainPoint) begin
        in_valid_i <= 1'b0;
        while (angles_due.size() != 0) @(negedge clk_i);
      end
      make_pair(ry, rx);
      offer(ry, rx, 1'b0, AngZero);
      idle_sender(sender_gap());
    end
    in_valid_i <= 1'b0;

    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver pacing. Runs of ready and stalled cycles of random length; once
  // the sender is well into the random run, one long stall lets the pipeline
  // fill and push back on the input while the sender keeps offering.
  initial begin : result_pacing
    int  r;
    int  len;
    bit  level;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && accepted_count >= HoldPoint) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          level = 1'b0;
          len   = $urandom_range(1, 10);
        end else if (r < 60) begin
          level = 1'b0;
          len   = $urandom_range(20, 80);
        end else if (r < 93) begin
          level = 1'b1;
          len   = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          len   = $urandom_range(10, 30);
        end
        out_stall_i <= level;
        repeat (len) @(negedge clk_i);
      end
    end
  end

  // Result check. Each transaction on the output channel is matched against
  // the oldest predicted angle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angles_due.size() == 0) begin
        $display("%0t ns: angle result with none pending: expected none, actual %0d",
                 $time, angle_deg_o);
        mismatch_count++;
      end else begin
        due_angle = angles_due.pop_front();
        if (angle_deg_o !== due_angle) begin
          $display("%0t ns: angle mismatch: expected %0d, actual %0d",
                   $time, due_angle, angle_deg_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(RunLimitNs);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
